// File: sv/spr_pkg.sv
package spr_pkg;

   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam int          RSP_DATA_W    = 48;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } spr_op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HEAD  = 3'd1,
      PH_PARAM = 3'd2,
      PH_CRCL  = 3'd3,
      PH_CRCH  = 3'd4
   } spr_phase_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DEVERR  = 3'd1,
      ST_CRC     = 3'd2,
      ST_HEADER  = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_SHORT   = 3'd5
   } spr_status_type;

   typedef struct packed {
      spr_op_type  op;
      logic [7:0]  byte_value;
   } spr_item_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      data_byte;
      logic [7:0]      servo_id;
      spr_status_type  status_code;
      logic [7:0]      device_error;
      logic [15:0]     param_count;
      logic            last;
   } spr_result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: sv/spr_parser.sv
module spr_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  spr_pkg::spr_item_type   item,
   input  logic [15:0]             timeout_ticks,
   output logic                    emit,
   output spr_pkg::spr_result_type result
);

   localparam logic [7:0] HEADER [4] = '{8'hFF, 8'hFF, 8'hFD, 8'h00};

   spr_pkg::spr_phase_type phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  err_ff, err_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crcl_ff, crcl_in;
   logic [15:0] ticks_ff, ticks_in;

   logic [15:0] crc_next;
   logic [15:0] count;
   logic [15:0] len_hi;
   logic [15:0] ticks_next;
   logic [15:0] pos_next;
   logic        head_bad;
   logic        is_short;
   logic        timed_out;
   logic        tick_live;

   assign crc_next   = spr_pkg::crc_byte(crc_ff, item.byte_value);
   assign count      = (len_ff >= 16'd4) ? (len_ff - 16'd4) : 16'd0;
   assign len_hi     = {item.byte_value, len_ff[7:0]};
   assign pos_next   = pos_ff + 16'd1;
   assign ticks_next = (ticks_ff != 16'hFFFF) ? (ticks_ff + 16'd1) : ticks_ff;
   assign head_bad   = (pos_ff < 16'd4) && (item.byte_value != HEADER[pos_ff[1:0]]);
   assign is_short   = (pos_ff == 16'd6) && (len_hi < 16'd4);
   assign tick_live  = (phase_ff == spr_pkg::PH_HEAD) && (pos_ff < 16'd7);
   assign timed_out  = ticks_next >= timeout_ticks;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      err_in   = err_ff;
      crc_in   = crc_ff;
      crcl_in  = crcl_ff;
      ticks_in = ticks_ff;
      if (fire) begin
         unique case (item.op)
            spr_pkg::OP_START: begin
               phase_in = spr_pkg::PH_HEAD;
               pos_in   = '0;
               len_in   = '0;
               id_in    = '0;
               err_in   = '0;
               crc_in   = '0;
               crcl_in  = '0;
               ticks_in = '0;
            end
            spr_pkg::OP_BYTE: begin
               unique case (phase_ff)
                  spr_pkg::PH_HEAD: begin
                     if (head_bad) begin
                        phase_in = spr_pkg::PH_IDLE;
                     end else begin
                        crc_in = crc_next;
                        pos_in = pos_next;
                        if (pos_ff == 16'd4) begin
                           id_in = item.byte_value;
                        end
                        if (pos_ff == 16'd5) begin
                           len_in = {8'h00, item.byte_value};
                        end
                        if (pos_ff == 16'd6) begin
                           len_in = len_hi;
                        end
                        if (is_short) begin
                           phase_in = spr_pkg::PH_IDLE;
                        end
                        if (pos_ff == 16'd8) begin
                           err_in   = item.byte_value;
                           pos_in   = '0;
                           phase_in = (count == 16'd0) ? spr_pkg::PH_CRCL : spr_pkg::PH_PARAM;
                        end
                     end
                  end
                  spr_pkg::PH_PARAM: begin
                     crc_in = crc_next;
                     pos_in = pos_next;
                     if (pos_next >= count) begin
                        phase_in = spr_pkg::PH_CRCL;
                     end
                  end
                  spr_pkg::PH_CRCL: begin
                     crcl_in  = item.byte_value;
                     phase_in = spr_pkg::PH_CRCH;
                  end
                  spr_pkg::PH_CRCH: begin
                     phase_in = spr_pkg::PH_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
            spr_pkg::OP_TICK: begin
               if (tick_live) begin
                  ticks_in = ticks_next;
                  if (timed_out) begin
                     phase_in = spr_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      emit                = 1'b0;
      result.kind         = 1'b1;
      result.data_byte    = '0;
      result.servo_id     = id_ff;
      result.status_code  = spr_pkg::ST_OK;
      result.device_error = err_ff;
      result.param_count  = '0;
      result.last         = 1'b1;
      unique case (item.op)
         spr_pkg::OP_BYTE: begin
            unique case (phase_ff)
               spr_pkg::PH_HEAD: begin
                  if (head_bad) begin
                     emit               = 1'b1;
                     result.status_code = spr_pkg::ST_HEADER;
                  end else if (is_short) begin
                     emit               = 1'b1;
                     result.status_code = spr_pkg::ST_SHORT;
                  end
               end
               spr_pkg::PH_PARAM: begin
                  emit                = (err_ff == 8'h00);
                  result.kind         = 1'b0;
                  result.data_byte    = item.byte_value;
                  result.device_error = '0;
                  result.param_count  = count;
                  result.last         = 1'b0;
               end
               spr_pkg::PH_CRCH: begin
                  emit               = 1'b1;
                  result.param_count = count;
                  if (err_ff != 8'h00) begin
                     result.status_code = spr_pkg::ST_DEVERR;
                  end else if ((crcl_ff != crc_ff[7:0]) || (item.byte_value != crc_ff[15:8])) begin
                     result.status_code = spr_pkg::ST_CRC;
                  end
               end
               default: begin
               end
            endcase
         end
         spr_pkg::OP_TICK: begin
            if (tick_live && timed_out) begin
               emit               = 1'b1;
               result.status_code = spr_pkg::ST_TIMEOUT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spr_pkg::PH_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         id_ff    <= '0;
         err_ff   <= '0;
         crc_ff   <= '0;
         crcl_ff  <= '0;
         ticks_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         err_ff   <= err_in;
         crc_ff   <= crc_in;
         crcl_ff  <= crcl_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

// File: sv/status_packet_receiver.sv
// Status packet receiver for a serial servo bus.
// Input items (req_*): req_tuser is the op (start, received byte, 1 us tick),
// req_tdata the received byte. A start arms the receiver and its timeout.
// Result items (rsp_*): rsp_tuser is 0 for a streamed parameter byte and 1 for
// the final status; rsp_tlast marks the final status. rsp_tdata carries the
// parameter byte, servo id, status code, device error and parameter count.
// csr_we/csr_wdata write the timeout in ticks (reset value 5000); write it
// only while no packet is in progress.
// An accepted item enters the input register and, once it can advance, is
// parsed into the output register, and any result it makes shows on
// rsp_tvalid. Throughput: one item per cycle while the output register is
// empty, rsp_tready is high or the item causes no result, set by the single
// parse stage with a one-byte CRC update between registers.
// When rsp_tready is low, the result holds and one more item is taken into
// the input register; req_tready then drops until the output drains, unless
// that item causes no result.
// Reset (synchronous, active high) empties both registers, returns the
// parser to idle and restores the timeout to its reset value.
module status_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [spr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // data_byte[7:0], servo_id[15:8], status_code[18:16], device_error[26:19],
   // param_count[42:27], zero fill
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic                    in_valid_ff;
   spr_pkg::spr_item_type   in_item_ff;
   logic                    rsp_valid_ff;
   spr_pkg::spr_result_type rsp_ff;
   logic [15:0]             timeout_ff;
   logic                    emit;
   logic                    advance;
   spr_pkg::spr_result_type result;

   assign advance    = in_valid_ff && (!emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   spr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .item          (in_item_ff),
      .timeout_ticks (timeout_ff),
      .emit          (emit),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= spr_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.op         <= spr_pkg::spr_op_type'(req_tuser);
         in_item_ff.byte_value <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {5'b00000, rsp_ff.param_count, rsp_ff.device_error,
                        rsp_ff.status_code, rsp_ff.servo_id, rsp_ff.data_byte};

endmodule

// File: tb/status_packet_receiver_checker.sv
module status_packet_receiver_checker
   import spr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   output int                    error_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] HDR_SYNC = 8'hFF;
   localparam logic [7:0] HDR_MARK = 8'hFD;
   localparam logic [7:0] HDR_PAD  = 8'h00;

   logic [15:0]    timeout_limit;
   spr_phase_type  phase;
   logic [15:0]    byte_pos;
   logic [15:0]    pkt_len;
   logic [15:0]    tick_count;
   logic [15:0]    crc_run;
   logic [7:0]     id_seen;
   logic [7:0]     err_seen;
   logic [7:0]     crc_low;
   spr_result_type pending_results[$];

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         if (c[15] ^ b[i]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] header_at(input logic [1:0] idx);
      case (idx)
         2'd2: return HDR_MARK;
         2'd3: return HDR_PAD;
         default: return HDR_SYNC;
      endcase
   endfunction

   function automatic logic [15:0] param_total();
      return (pkt_len >= 16'd4) ? pkt_len - 16'd4 : 16'd0;
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic post_status(input spr_status_type code, input logic [15:0] count);
      spr_result_type r;
      r.kind         = 1'b1;
      r.data_byte    = 8'h00;
      r.servo_id     = id_seen;
      r.status_code  = code;
      r.device_error = err_seen;
      r.param_count  = count;
      r.last         = 1'b1;
      pending_results.push_back(r);
      phase = PH_IDLE;
   endtask

   task automatic post_param(input logic [7:0] b);
      spr_result_type r;
      r.kind         = 1'b0;
      r.data_byte    = b;
      r.servo_id     = id_seen;
      r.status_code  = ST_OK;
      r.device_error = 8'h00;
      r.param_count  = param_total();
      r.last         = 1'b0;
      pending_results.push_back(r);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [15:0] pos;
      pos = byte_pos;
      case (phase)
         PH_HEAD: begin
            if (pos < 16'd4 && b != header_at(pos[1:0])) begin
               post_status(ST_HEADER, 16'd0);
            end else begin
               if (pos == 16'd4) begin
                  id_seen = b;
               end else if (pos == 16'd5) begin
                  pkt_len = {8'h00, b};
               end else if (pos == 16'd6) begin
                  pkt_len[15:8] = b;
               end else if (pos == 16'd8) begin
                  err_seen = b;
               end
               crc_run  = crc_step(crc_run, b);
               byte_pos = pos + 16'd1;
               if (pos == 16'd6 && pkt_len < 16'd4) begin
                  post_status(ST_SHORT, 16'd0);
               end else if (pos == 16'd8) begin
                  byte_pos = 16'd0;
                  phase = (param_total() == 16'd0) ? PH_CRCL : PH_PARAM;
               end
            end
         end
         PH_PARAM: begin
            crc_run = crc_step(crc_run, b);
            if (err_seen == 8'h00) begin
               post_param(b);
            end
            byte_pos = byte_pos + 16'd1;
            if (byte_pos >= param_total()) begin
               phase = PH_CRCL;
            end
         end
         PH_CRCL: begin
            crc_low = b;
            phase = PH_CRCH;
         end
         PH_CRCH: begin
            if (err_seen != 8'h00) begin
               post_status(ST_DEVERR, param_total());
            end else if (crc_low != crc_run[7:0] || b != crc_run[15:8]) begin
               post_status(ST_CRC, param_total());
            end else begin
               post_status(ST_OK, param_total());
            end
         end
         default: ;
      endcase
   endtask

   task automatic parse_item(input logic [1:0] op, input logic [7:0] b);
      case (op)
         OP_START: begin
            phase      = PH_HEAD;
            byte_pos   = 16'd0;
            pkt_len    = 16'd0;
            id_seen    = 8'h00;
            err_seen   = 8'h00;
            crc_run    = 16'd0;
            crc_low    = 8'h00;
            tick_count = 16'd0;
         end
         OP_BYTE: begin
            parse_byte(b);
         end
         OP_TICK: begin
            if (phase == PH_HEAD && byte_pos < 16'd7) begin
               if (tick_count != 16'hFFFF) begin
                  tick_count++;
               end
               if (tick_count >= timeout_limit) begin
                  post_status(ST_TIMEOUT, 16'd0);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      spr_result_type want;
      if (pending_results.size() == 0) begin
         report($sformatf("unexpected result: tuser %b tlast %b tdata %h",
                          rsp_tuser, rsp_tlast, rsp_tdata));
      end else begin
         want = pending_results.pop_front();
         if (rsp_tuser != want.kind)
            report($sformatf("kind: got %0d, want %0d", rsp_tuser, want.kind));
         if (rsp_tdata[7:0] != want.data_byte)
            report($sformatf("data_byte: got %h, want %h", rsp_tdata[7:0], want.data_byte));
         if (rsp_tdata[15:8] != want.servo_id)
            report($sformatf("servo_id: got %h, want %h", rsp_tdata[15:8], want.servo_id));
         if (rsp_tdata[18:16] != want.status_code)
            report($sformatf("status_code: got %0d, want %0d",
                             rsp_tdata[18:16], want.status_code));
         if (rsp_tdata[26:19] != want.device_error)
            report($sformatf("device_error: got %h, want %h",
                             rsp_tdata[26:19], want.device_error));
         if (rsp_tdata[42:27] != want.param_count)
            report($sformatf("param_count: got %0d, want %0d",
                             rsp_tdata[42:27], want.param_count));
         if (rsp_tlast != want.last)
            report($sformatf("last: got %0d, want %0d", rsp_tlast, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_limit = TIMEOUT_RESET;
         phase         = PH_IDLE;
         byte_pos      = 16'd0;
         pkt_len       = 16'd0;
         tick_count    = 16'd0;
         crc_run       = 16'd0;
         id_seen       = 8'h00;
         err_seen      = 8'h00;
         crc_low       = 8'h00;
         error_count   = 0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (csr_we) begin
            timeout_limit = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            parse_item(req_tuser, req_tdata);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// File: tb/status_packet_receiver_tb.sv
module status_packet_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spr_pkg::*;

   localparam int          STALL_MAX    = 8;
   localparam int          LONG_HOLD    = 300;
   localparam int          IDLE_LIMIT   = 3000;
   localparam int          RANDOM_ITEMS = 960;
   localparam int          SETTINGS_CNT = 6;
   localparam logic [1:0]  OP_SPARE     = 2'd3;

   typedef enum int {CLEAN, BAD_HEADER, SHORT_LEN, CUT_SHORT, HUGE_LEN} frame_shape_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [15:0]           csr_wdata;

   int         error_count;
   int         outstanding;
   int         items_sent    = 0;
   int         idle_cycles   = 0;
   bit         quiet         = 1'b0;
   bit         long_hold_req = 1'b0;
   logic [7:0] frame_buf [0:63];
   int         frame_len;

   status_packet_receiver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   status_packet_receiver_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            stall = LONG_HOLD;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, STALL_MAX);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      return c;
   endfunction

   task automatic put(input logic [1:0] op, input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, STALL_MAX);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // hold the input idle until every expected item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_frame(input frame_shape_type shape, input bit big, input bit ticks);
      int          n_par;
      int          stop;
      int          bad;
      logic [15:0] len;
      logic [15:0] crc;
      n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (big) begin
         n_par = 40;
      end
      len = 16'(n_par + 4);
      if (shape == SHORT_LEN) begin
         len = 16'($urandom_range(0, 3));
      end else if (shape == HUGE_LEN) begin
         len[15:8] = 8'($urandom_range(1, 255));
         len[7:0]  = 8'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            len = 16'hFFFF;
         end
      end
      frame_buf[0] = 8'hFF;
      frame_buf[1] = 8'hFF;
      frame_buf[2] = 8'hFD;
      frame_buf[3] = 8'h00;
      frame_buf[4] = 8'($urandom);
      frame_buf[5] = len[7:0];
      frame_buf[6] = len[15:8];
      frame_buf[7] = 8'($urandom);
      frame_buf[8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      for (int k = 0; k < n_par; k++) begin
         frame_buf[9 + k] = 8'($urandom);
      end
      frame_len = 9 + n_par;
      crc = 16'd0;
      for (int k = 0; k < frame_len; k++) begin
         crc = crc_add(crc, frame_buf[k]);
      end
      frame_buf[frame_len]     = crc[7:0];
      frame_buf[frame_len + 1] = crc[15:8];
      frame_len += 2;
      if ($urandom_range(0, 6) == 0) begin
         frame_buf[frame_len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      case (shape)
         BAD_HEADER: begin
            bad = $urandom_range(0, 3);
            frame_buf[bad] ^= 8'($urandom_range(1, 255));
            stop = bad + 1;
         end
         SHORT_LEN: stop = 7;
         CUT_SHORT: stop = $urandom_range(1, frame_len - 1);
         HUGE_LEN:  stop = 9 + $urandom_range(0, n_par);
         default:   stop = frame_len;
      endcase
      put(OP_START, 8'($urandom));
      for (int k = 0; k < stop; k++) begin
         if (ticks && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) put(OP_TICK, 8'($urandom));
         end
         put(OP_BYTE, frame_buf[k]);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4)) put(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   initial begin : stimulus
      logic [15:0] tmo;
      int          goal;
      int          pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= OP_START;
      csr_we     <= 1'b0;
      csr_wdata  <= 16'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      put(OP_BYTE, 8'hFF);
      put(OP_TICK, 8'h00);
      put(OP_SPARE, 8'h55);
      put(OP_START, 8'h00);
      put(OP_BYTE, 8'hFF);
      put(OP_BYTE, 8'h00);
      put(OP_START, 8'hFF);
      put(OP_BYTE, 8'hFF);
      put(OP_START, 8'h00);
      put(OP_BYTE, 8'hFF);
      put(OP_BYTE, 8'hFF);
      put(OP_BYTE, 8'hFD);
      put(OP_BYTE, 8'h00);
      put(OP_BYTE, 8'hFF);
      put(OP_BYTE, 8'h03);
      put(OP_BYTE, 8'h00);
      write_timeout(16'd0);
      put(OP_START, 8'h00);
      put(OP_TICK, 8'hFF);

      tmo = 16'($urandom_range(256, 511));
      write_timeout(tmo);
      quiet = 1'b1;
      put(OP_START, 8'h00);
      repeat (tmo + 2) put(OP_TICK, 8'($urandom));

      write_timeout(TIMEOUT_RESET);
      long_hold_req = 1'b1;
      send_frame(CLEAN, 1'b1, 1'b0);
      quiet = 1'b0;

      for (int p = 0; p < SETTINGS_CNT; p++) begin
         case (p)
            0: tmo = 16'hFFFF;
            1: tmo = 16'($urandom_range(2, 30));
            2: tmo = 16'd1;
            3: tmo = TIMEOUT_RESET;
            4: tmo = 16'($urandom_range(31, 400));
            default: tmo = 16'd0;
         endcase
         write_timeout(tmo);
         goal = items_sent + RANDOM_ITEMS / SETTINGS_CNT;
         while (items_sent < goal) begin
            quiet = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 19);
            if (pick < 12) begin
               send_frame(CLEAN, 1'b0, $urandom_range(0, 2) == 0);
            end else if (pick < 14) begin
               send_frame(BAD_HEADER, 1'b0, 1'b1);
            end else if (pick < 15) begin
               send_frame(SHORT_LEN, 1'b0, 1'b1);
            end else if (pick < 16) begin
               send_frame(CUT_SHORT, 1'b0, 1'b1);
            end else if (pick < 17) begin
               send_frame(HUGE_LEN, 1'b0, 1'b0);
            end else begin
               send_noise();
            end
         end
      end

      quiet = 1'b0;
      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
